// ===== rtl/core/iprt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 prefix route table package
// Field widths, operation and status codes, table entry layout and the
// command group passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package iprt_pkg;

    // Default table size
    localparam int IPRT_TABLE_ENTRIES = 16;

    // Field widths
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int STACK_W = 8;
    localparam int AGE_W   = 8;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    // Longest legal prefix; longer lengths are clamped to it
    localparam logic [LEN_W-1:0] PREFIX_MAX = LEN_W'(32);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AGE    = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

    // Configuration register map (register index)
    localparam logic REG_AGE_REFRESH = 1'b0;
    localparam logic [AGE_W-1:0] AGE_REFRESH_RESET = 8'd1;

    // One table slot as held in memory
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   length;
        logic [STACK_W-1:0] stack;
        logic [AGE_W-1:0]   age;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture a new item, clear the scan trackers
        logic rd_en;   // read the slot at the scan index
        logic clr_en;  // write an empty slot at the scan index
        logic finish;  // write back, present the result
    } dp_cmd_t;

    // Network mask for a prefix length of 0..32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

endpackage

// ===== rtl/core/iprt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 prefix route table channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface iprt_req_if;
    import iprt_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  address;
    logic [LEN_W-1:0]   prefix_len;
    logic [STACK_W-1:0] target_stack;

    modport source (output valid, output mode, output address, output prefix_len,
                    output target_stack, input ready);
    modport sink   (input valid, input mode, input address, input prefix_len,
                    input target_stack, output ready);
endinterface

interface iprt_rsp_if;
    import iprt_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [STACK_W-1:0] found_stack;

    modport source (output valid, output status, output found_stack, input ready);
    modport sink   (input valid, input status, input found_stack, output ready);
endinterface

// ===== rtl/core/iprt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iprt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/iprt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 prefix route table controller
// Sequences the clearing pass, the slot scan and the write-back/result step.
// ----------------------------------------------------------------------------
module iprt_ctrl #(
    parameter int TABLE_ENTRIES = iprt_pkg::IPRT_TABLE_ENTRIES,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              out_free,
    output iprt_pkg::dp_cmd_t cmd,
    output logic [IDX_W-1:0]  idx
);
    import iprt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_LAST  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                // last slot's read data is being processed
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    assign idx = cnt_reg;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // An accepted transfer always starts a scan from slot zero
    a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("scan did not start after request transfer");

    // The scan always runs to completion through the last slot
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cnt_reg == LAST_IDX) |=> (state_reg == ST_LAST))
        else $error("scan did not end after last slot");

endmodule

// ===== rtl/core/iprt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 prefix route table datapath
// Slot memory, per-slot match logic, scan trackers and result register.
// ----------------------------------------------------------------------------
module iprt_datapath #(
    parameter int TABLE_ENTRIES = iprt_pkg::IPRT_TABLE_ENTRIES,
    parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  iprt_pkg::dp_cmd_t            cmd,
    input  logic [IDX_W-1:0]             idx,
    input  logic [iprt_pkg::AGE_W-1:0]   age_refresh,
    input  logic [iprt_pkg::MODE_W-1:0]  req_mode,
    input  logic [iprt_pkg::ADDR_W-1:0]  req_address,
    input  logic [iprt_pkg::LEN_W-1:0]   req_prefix_len,
    input  logic [iprt_pkg::STACK_W-1:0] req_target_stack,
    output logic                         out_free,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [iprt_pkg::STAT_W-1:0]  rsp_status,
    output logic [iprt_pkg::STACK_W-1:0] rsp_found_stack
);
    import iprt_pkg::*;

    localparam int ENTRY_W = $bits(entry_t);

    // Captured item
    logic [MODE_W-1:0]  mode_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  key_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [STACK_W-1:0] stack_reg;
    logic [LEN_W-1:0]   len_clamped;

    // Read pipeline
    logic               rd_en_q_reg;
    logic [IDX_W-1:0]   rd_addr_q_reg;

    // Scan trackers
    logic               best_found_reg;
    logic [LEN_W-1:0]   best_len_reg;
    logic [STACK_W-1:0] best_stack_reg;
    logic               hit_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    // Memory ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             wr_entry;

    // Result register
    logic               rsp_valid_reg;
    logic [STAT_W-1:0]  rsp_status_reg;
    logic [STACK_W-1:0] rsp_stack_reg;
    logic [STAT_W-1:0]  status_c;
    logic [STACK_W-1:0] found_c;

    logic lookup_match;
    logic insert_match;

    iprt_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (idx),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Item capture; insert key is masked to the clamped length
    assign len_clamped = (req_prefix_len > PREFIX_MAX) ? PREFIX_MAX : req_prefix_len;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= req_mode;
            addr_reg  <= req_address;
            len_reg   <= len_clamped;
            key_reg   <= req_address & prefix_mask(len_clamped);
            stack_reg <= req_target_stack;
        end
    end

    // Read data qualifier and slot index, registered in step with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_en_q_reg <= 1'b0;
        end
        else
        begin
            rd_en_q_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_q_reg <= idx;
    end

    // Per-slot match
    assign lookup_match = rd_entry.valid &&
                          ((addr_reg & prefix_mask(rd_entry.length)) == rd_entry.prefix);
    assign insert_match = rd_entry.valid && (rd_entry.length == len_reg) &&
                          (rd_entry.prefix == key_reg);

    // Tracker flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            best_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (rd_en_q_reg)
        begin
            if (lookup_match)
            begin
                best_found_reg <= 1'b1;
            end
            if (insert_match)
            begin
                hit_found_reg <= 1'b1;
            end
            if (!rd_entry.valid)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Tracker payload: longest match, first duplicate, lowest free slot
    always_ff @(posedge clk)
    begin
        if (rd_en_q_reg)
        begin
            if (lookup_match && (!best_found_reg || rd_entry.length > best_len_reg))
            begin
                best_len_reg   <= rd_entry.length;
                best_stack_reg <= rd_entry.stack;
            end
            if (insert_match && !hit_found_reg)
            begin
                hit_idx_reg <= rd_addr_q_reg;
            end
            if (!rd_entry.valid && !free_found_reg)
            begin
                free_idx_reg <= rd_addr_q_reg;
            end
        end
    end

    // Memory write: clearing pass, age update in flight, insert at the end
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rd_addr_q_reg;
        wr_entry  = rd_entry;
        if (cmd.clr_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx;
            wr_entry  = '0;
        end
        else if (rd_en_q_reg && mode_reg == MODE_AGE && rd_entry.valid)
        begin
            ram_we = 1'b1;
            if (rd_entry.age == '0)
            begin
                wr_entry.valid = 1'b0;
            end
            else
            begin
                wr_entry.age = rd_entry.age - 1'b1;
            end
        end
        else if (cmd.finish && mode_reg == MODE_INSERT && (hit_found_reg || free_found_reg))
        begin
            ram_we          = 1'b1;
            ram_waddr       = hit_found_reg ? hit_idx_reg : free_idx_reg;
            wr_entry.valid  = 1'b1;
            wr_entry.prefix = key_reg;
            wr_entry.length = len_reg;
            wr_entry.stack  = stack_reg;
            wr_entry.age    = age_refresh;
        end
    end

    // Result value
    always_comb
    begin
        status_c = STATUS_OK;
        found_c  = '0;
        case (mode_reg)
            MODE_LOOKUP:
            begin
                if (best_found_reg)
                begin
                    found_c = best_stack_reg;
                end
                else
                begin
                    status_c = STATUS_MISS;
                end
            end
            MODE_INSERT:
            begin
                if (!hit_found_reg && !free_found_reg)
                begin
                    status_c = STATUS_FULL;
                end
            end
            default:
            begin
                status_c = STATUS_OK;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_status_reg <= status_c;
            rsp_stack_reg  <= found_c;
        end
    end

    assign out_free        = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp_status      = rsp_status_reg;
    assign rsp_found_stack = rsp_stack_reg;

    // Write-back never overlaps the scan
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rd_en_q_reg && !cmd.rd_en))
        else $error("write-back during slot scan");

    // A held result is never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |-> !cmd.finish)
        else $error("result overwritten while pending");

    // Longest match comes from stored lengths, never beyond 32
    a_best_len: assert property (@(posedge clk) disable iff (!rst_n)
        best_found_reg |-> (best_len_reg <= PREFIX_MAX))
        else $error("best prefix length out of range");

endmodule

// ===== rtl/core/ipv4_prefix_route_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 prefix route table
// Longest-prefix-match route table with insert/update and age ticks.
// Items: one at a time; a new request is taken only after the previous item's
//   scan of all slots, through the single read port of the slot memory, and its
//   result step, which waits while a held result has not yet been taken.
// Reset: rst_n is asynchronous; after it a clearing pass over all slots empties
//   the table, with req.ready low. Register writes are taken throughout.
// ----------------------------------------------------------------------------
module ipv4_prefix_route_table_top #(
    parameter int TABLE_ENTRIES = iprt_pkg::IPRT_TABLE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    iprt_req_if.sink    req,
    iprt_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import iprt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [AGE_W-1:0] age_refresh_reg;
    logic             reg_sel;
    dp_cmd_t          cmd;
    logic [IDX_W-1:0] idx;
    logic             out_free;

    // Register file: one register, selected by the word index bit
    assign reg_sel = (paddr[2] == REG_AGE_REFRESH);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_refresh_reg <= AGE_REFRESH_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            age_refresh_reg <= pwdata[AGE_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32 - AGE_W){1'b0}}, age_refresh_reg} : '0;

    iprt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .out_free  (out_free),
        .cmd       (cmd),
        .idx       (idx)
    );

    iprt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .idx              (idx),
        .age_refresh      (age_refresh_reg),
        .req_mode         (req.mode),
        .req_address      (req.address),
        .req_prefix_len   (req.prefix_len),
        .req_target_stack (req.target_stack),
        .out_free         (out_free),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_status       (rsp.status),
        .rsp_found_stack  (rsp.found_stack)
    );

endmodule
